// ----- rtl/mgb_pkg.sv -----
package mgb_pkg;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int PIX_W = 32;
  localparam int LAB_W = 16;
  localparam int ENT_W = PIX_W + LAB_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  typedef logic [ENT_W-1:0] ent_t;

  // Kernel weight for window position (1 2 1 / 2 4 2 / 1 2 1).
  function automatic logic [2:0] kweight(input int i);
    case (i)
      4:             kweight = 3'd4;
      1, 3, 5, 7:    kweight = 3'd2;
      default:       kweight = 3'd1;
    endcase
  endfunction
endpackage

// ----- rtl/mgb_if.sv -----
interface pix_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  logic [15:0] mask_label;
  modport source (output valid, pixel_in, mask_label, input ready);
  modport sink   (input valid, pixel_in, mask_label, output ready);
endinterface

interface pix_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic [10:0] out_col;
  logic [11:0] out_row;
  logic        was_filtered;
  logic        last_of_run;
  modport source (output valid, pixel_out, out_col, out_row, was_filtered, last_of_run,
                  input ready);
  modport sink   (input valid, pixel_out, out_col, out_row, was_filtered, last_of_run,
                  output ready);
endinterface

interface cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mgb_ram.sv -----
module mgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/mgb_divider.sv -----
// Four-channel restoring divider, one quotient bit per cycle.
// Divisor is the summed weight, 4..16.
module mgb_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [11:0] num [4],
  input  logic [4:0]  den,
  output logic        busy,
  output logic        done,
  output logic [31:0] quo
);
  logic [11:0] rem [4];
  logic [7:0]  q [4];
  logic [3:0]  cnt;
  logic [4:0]  d;

  always_ff @(posedge clk) begin
    // pulse with the last quotient bit
    done <= !rst && !start && busy && (cnt == 4'd1);
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'd8;
      d    <= den;
      for (int ch = 0; ch < 4; ch++) begin
        rem[ch] <= num[ch];
        q[ch]   <= '0;
      end
    end else if (busy) begin
      for (int ch = 0; ch < 4; ch++) begin
        // quotient fits 8 bits since sum <= 255*den
        if ({9'd0, rem[ch] >> (cnt - 4'd1)} >= {16'd0, d}) begin
          rem[ch] <= rem[ch] - 12'({d, 7'd0} >> (4'd8 - cnt));
          q[ch]   <= {q[ch][6:0], 1'b1};
        end else begin
          q[ch] <= {q[ch][6:0], 1'b0};
        end
      end
      cnt <= cnt - 4'd1;
      if (cnt == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = {q[3], q[2], q[1], q[0]};
endmodule

// ----- rtl/masked_gaussian_blur_3x3.sv -----
// An interior result passes window update, sum, divider load, 8 divider steps and
// the output register before its first beat; a border pixel alone is passed through
// from the sum state. The border beat follows the interior one.
// Throughput: one pixel in flight; the next pixel is taken only once every result beat
// of the last one has been accepted.
// Reset (rst, synchronous): position, window and registers to defaults; line stores kept.
module masked_gaussian_blur_3x3 #(
  parameter int MAX_WIDTH  = mgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mgb_pkg::MAX_HEIGHT_DEF
) (
  input logic clk,
  input logic rst,
  pix_in_if.sink    pin,
  pix_out_if.source pout,
  cfg_if.sink       cfg
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = CW + 1;
  localparam int PH = RW + 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SUM, S_DIV, S_OUT1, S_OUT2} state_t;
  state_t state;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [PW-1:0] w_eff;
  logic [PH-1:0] h_eff;

  // effective size, clamped to [3, MAX]
  always_comb begin
    if ({20'd0, image_width} < 32'd3) w_eff = PW'(3);
    else if ({20'd0, image_width} > 32'(MAX_WIDTH)) w_eff = PW'(MAX_WIDTH);
    else w_eff = PW'(image_width);
    if ({19'd0, image_height} < 32'd3) h_eff = PH'(3);
    else if ({19'd0, image_height} > 32'(MAX_HEIGHT)) h_eff = PH'(MAX_HEIGHT);
    else h_eff = PH'(image_height);
  end

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mgb_pkg::WIDTH_RESET;
      image_height <= mgb_pkg::HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mgb_pkg::REG_WIDTH:  image_width  <= cfg.data[11:0];
        mgb_pkg::REG_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // position of next pixel, kept one bit wider than the index for wrap compares
  logic [PW-1:0] col_count;
  logic [PH-1:0] row_count;
  logic [PW-1:0] c_pre;
  logic [PH-1:0] r_pre;
  // wrap on entry if size shrank mid-frame
  always_comb begin
    c_pre = col_count;
    r_pre = row_count;
    if (c_pre >= w_eff) begin
      c_pre = '0;
      r_pre = r_pre + PH'(1);
    end
    if (r_pre >= h_eff) r_pre = '0;
  end

  localparam int PIX_W_L = mgb_pkg::PIX_W;
  logic [PW-1:0] c;
  logic [PH-1:0] r;
  logic [PIX_W_L-1:0] pix;
  mgb_pkg::ent_t neu;
  mgb_pkg::ent_t win [9];
  mgb_pkg::ent_t up_rd, lo_rd;

  logic ram_we;
  mgb_ram #(.WIDTH(mgb_pkg::ENT_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(ram_we), .waddr(c[CW-1:0]), .wdata(lo_rd),
    .raddr(c_pre[CW-1:0]), .rdata(up_rd));
  mgb_ram #(.WIDTH(mgb_pkg::ENT_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk(clk), .we(ram_we), .waddr(c[CW-1:0]), .wdata(neu),
    .raddr(c_pre[CW-1:0]), .rdata(lo_rd));
  assign ram_we = (state == S_READ);

  // weighted sums, registered into the divider
  logic [11:0] sum [4];
  logic [4:0]  tot;
  always_comb begin
    for (int ch = 0; ch < 4; ch++) sum[ch] = '0;
    tot = '0;
    for (int i = 0; i < 9; i++) begin
      if (win[i][47:32] == win[4][47:32]) begin
        for (int ch = 0; ch < 4; ch++)
          sum[ch] = sum[ch] + 12'(mgb_pkg::kweight(i)) * {4'd0, win[i][8*ch +: 8]};
        tot = tot + 5'(mgb_pkg::kweight(i));
      end
    end
  end
  logic [11:0] sum_q [4];
  logic [4:0]  tot_q;
  logic        div_start, div_busy, div_done;
  logic [31:0] div_q;
  mgb_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(sum_q), .den(tot_q),
    .busy(div_busy), .done(div_done), .quo(div_q));

  logic interior, border;
  assign interior = (r >= PH'(2)) && (c >= PW'(2));
  assign border = (r == '0) || (r == h_eff - PH'(1)) || (c == '0) || (c == w_eff - PW'(1));

  assign pin.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    // divider starts the cycle after the sums are registered
    div_start <= !rst && (state == S_SUM) && interior;
    if (rst) begin
      state     <= S_IDLE;
      col_count <= '0;
      row_count <= '0;
      pout.valid <= 1'b0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (pin.valid) begin
          c   <= c_pre;
          r   <= r_pre;
          pix <= pin.pixel_in;
          neu <= {pin.mask_label, pin.pixel_in};
          state <= S_READ;
        end
        S_READ: begin
          // RAM data valid now; shift window, write back
          for (int i = 0; i < 3; i++) begin
            win[i*3]   <= win[i*3+1];
            win[i*3+1] <= win[i*3+2];
          end
          win[2] <= up_rd;
          win[5] <= lo_rd;
          win[8] <= neu;
          if (c + PW'(1) >= w_eff) begin
            col_count <= '0;
            row_count <= (r + PH'(1) >= h_eff) ? '0 : r + PH'(1);
          end else begin
            col_count <= c + PW'(1);
            row_count <= r;
          end
          state <= S_SUM;
        end
        S_SUM: begin
          sum_q <= sum;
          tot_q <= tot;
          if (interior) begin
            state <= S_DIV;
          end else if (border) begin
            pout.valid        <= 1'b1;
            pout.pixel_out    <= pix;
            pout.out_col      <= 11'(c);
            pout.out_row      <= 12'(r);
            pout.was_filtered <= 1'b0;
            pout.last_of_run  <= 1'b1;
            state <= S_OUT2;
          end else begin
            // row 1 or column 1 away from the edges: nothing to emit
            state <= S_IDLE;
          end
        end
        S_DIV: if (div_done) begin
          pout.valid        <= 1'b1;
          pout.pixel_out    <= div_q;
          pout.out_col      <= 11'(c - PW'(1));
          pout.out_row      <= 12'(r - PH'(1));
          pout.was_filtered <= 1'b1;
          pout.last_of_run  <= !border;
          state <= S_OUT1;
        end
        S_OUT1: if (pout.ready) begin
          if (border) begin
            pout.pixel_out    <= pix;
            pout.out_col      <= 11'(c);
            pout.out_row      <= 12'(r);
            pout.was_filtered <= 1'b0;
            pout.last_of_run  <= 1'b1;
            state <= S_OUT2;
          end else begin
            pout.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_OUT2: if (pout.ready) begin
          pout.valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- tb/masked_gaussian_blur_3x3_tb.sv -----
module masked_gaussian_blur_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = mgb_pkg::MAX_WIDTH_DEF;
  localparam int MAXH = mgb_pkg::MAX_HEIGHT_DEF;
  // Drain margin, well beyond the time a pixel needs to clear the block without output stalls.
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [31:0] pixel;
    logic [10:0] col;
    logic [11:0] row;
    logic        filt;
    logic        last;
  } blur_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pix_in_if  pin ();
  pix_out_if pout ();
  cfg_if     cfg ();

  masked_gaussian_blur_3x3 u_dut (
    .clk  (clk),
    .rst  (rst),
    .pin  (pin.sink),
    .pout (pout.source),
    .cfg  (cfg.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: its own copy of line stores, window, position and size.
  logic [47:0] row_above2 [MAXW];
  logic [47:0] row_above1 [MAXW];
  logic [47:0] win [9];
  int unsigned col_pos, row_pos;
  int unsigned width_reg, height_reg;

  blur_beat_t expected_beats[$];
  int err_count = 0;
  int stall_hold = 0;   // receiver hold-off cycles requested
  int rx_wait = 0;      // receiver wait left before the next beat
  bit rx_random = 1'b1;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Masked 1-2-1 binomial filter over the current window.
  function automatic logic [31:0] masked_blur();
    logic [15:0] ctr;
    int unsigned acc [4];
    int unsigned wsum;
    int unsigned wt;
    logic [31:0] res;
    ctr = win[4][47:32];
    wsum = 0;
    res = '0;
    for (int ch = 0; ch < 4; ch++) acc[ch] = 0;
    for (int i = 0; i < 9; i++) begin
      wt = (i == 4) ? 4 : ((i % 2) == 1) ? 2 : 1;
      if (win[i][47:32] == ctr) begin
        for (int ch = 0; ch < 4; ch++) acc[ch] += wt * win[i][8*ch +: 8];
        wsum += wt;
      end
    end
    for (int ch = 0; ch < 4; ch++) res[8*ch +: 8] = 8'(acc[ch] / wsum);
    return res;
  endfunction

  // Advance the predictor by one accepted pixel and queue its results.
  task automatic predict_pixel(input logic [31:0] pix, input logic [15:0] lab);
    int unsigned w, h, c, r;
    int n0;
    blur_beat_t b;
    w = clamp_dim(width_reg, MAXW);
    h = clamp_dim(height_reg, MAXH);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = row_above2[c];
    win[5] = row_above1[c];
    win[8] = {lab, pix};
    row_above2[c] = row_above1[c];
    row_above1[c] = {lab, pix};
    n0 = expected_beats.size();
    if (r >= 2 && c >= 2) begin
      b = '{masked_blur(), 11'(c - 1), 12'(r - 1), 1'b1, 1'b0};
      expected_beats.push_back(b);
    end
    if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
      b = '{pix, 11'(c), 12'(r), 1'b0, 1'b0};
      expected_beats.push_back(b);
    end
    if (expected_beats.size() > n0) expected_beats[$].last = 1'b1;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // --- Stimulus side ---
  int unsigned tx_gap_max = 16;

  task automatic send_pixel(input logic [31:0] pix, input logic [15:0] lab);
    int gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      pin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin.valid      <= 1'b1;
    pin.pixel_in   <= pix;
    pin.mask_label <= lab;
    do @(posedge clk); while (!pin.ready);
    predict_pixel(pix, lab);
  endtask

  task automatic idle_input();
    pin.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected beat, then let the pipeline settle.
  task automatic wait_drained();
    idle_input();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == mgb_pkg::REG_WIDTH) width_reg = 32'(val[11:0]);
    else height_reg = 32'(val);
    @(posedge clk);
  endtask

  // Size change only between frames: restart the predictor's position too,
  // by completing frames exactly; the block then sits at (0,0) as well.
  task automatic set_size(input logic [12:0] w, input logic [12:0] h);
    wait_drained();
    write_reg(mgb_pkg::REG_WIDTH, w);
    write_reg(mgb_pkg::REG_HEIGHT, h);
  endtask

  // One full frame; kind selects label pattern (and, for the default kind, the pixels).
  task automatic send_frame(input int kind);
    int unsigned w, h;
    logic [31:0] pix;
    logic [15:0] lab;
    w = clamp_dim(width_reg, MAXW);
    h = clamp_dim(height_reg, MAXH);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        pix = $urandom();
        case (kind)
          0: lab = 16'h0;                                   // single shape
          1: lab = 16'($urandom_range(0, 2));               // few shapes
          2: lab = (c < w/2) ? 16'h0000 : 16'hFFFF;         // split edge
          3: lab = 16'($urandom());                          // random labels
          default: begin
            lab = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
            pix = ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : 32'h0;
          end
        endcase
        send_pixel(pix, lab);
      end
  endtask

  // --- Tests ---
  task automatic test_directed();
    // Smallest frame, extreme pixels and labels; all-max vs all-zero.
    set_size(13'd3, 13'd3);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 2) ? 32'hFFFF_FFFF : 32'h0, (i == 4) ? 16'hFFFF : 16'h0);
    // Centre matches all neighbours, saturated values.
    for (int i = 0; i < 9; i++) send_pixel(32'hFFFF_FFFF, 16'h1234);
    wait_drained();
  endtask

  task automatic test_register_clamp();
    // Out-of-range values clamp to 3 and max.
    set_size(13'd0, 13'd2);
    send_frame(1);
    // width 4095 clamps to 2048: a short run stays in row 0
    set_size(13'd4095, 13'd3);
    for (int i = 0; i < 20; i++) send_pixel($urandom(), 16'($urandom_range(0, 1)));
    wait_drained();
    // narrowing mid-row wraps to the start of row 1; two rows end the frame
    write_reg(mgb_pkg::REG_WIDTH, 13'd5);
    for (int i = 0; i < 10; i++) send_pixel($urandom(), 16'($urandom_range(0, 1)));
    wait_drained();
    set_size(13'd5, 13'd8191);     // height 8191 clamps to 4096: run 2 rows only
    for (int i = 0; i < 10; i++) send_pixel($urandom(), 16'($urandom_range(0, 1)));
    wait_drained();
    // Position now row 2; height 3 makes it the last row, closing the frame.
    write_reg(mgb_pkg::REG_HEIGHT, 13'd3);
    for (int i = 0; i < 5; i++) send_pixel($urandom(), 16'h0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_size(13'd8, 13'd5);
    stall_hold = 400;           // receiver holds off while the sender pushes on
    tx_gap_max = 0;
    send_frame(1);
    tx_gap_max = 16;
    wait_drained();
  endtask

  task automatic test_random();
    int sent = 0;
    int kind;
    logic [12:0] w, h;
    while (sent < 1440) begin
      w = 13'($urandom_range(3, 12));
      h = 13'($urandom_range(3, 8));
      set_size(w, h);
      rx_random = ($urandom_range(0, 3) != 0);
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      kind = $urandom_range(0, 4);
      send_frame(kind);
      sent += clamp_dim(w, MAXW) * clamp_dim(h, MAXH);
    end
    rx_random = 1'b1;
    tx_gap_max = 16;
  endtask

  // --- Receiver: a drawn wait per beat in random mode, plus a requested long hold-off ---
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      pout.ready <= 1'b0;
      rx_wait <= 0;
    end else if (stall_hold > 0) begin
      pout.ready <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else if (!rx_random) begin
      pout.ready <= 1'b1;
    end else if (rx_wait > 0) begin
      pout.ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (pout.valid && pout.ready) begin
      // beat taken: draw the wait before the next one
      draw = $urandom_range(0, 16);
      if (draw > 0) begin
        pout.ready <= 1'b0;
        rx_wait <= draw - 1;
      end else begin
        pout.ready <= 1'b1;
      end
    end else begin
      pout.ready <= 1'b1;
    end
  end

  // --- Checker: compares each accepted result beat with the oldest expectation ---
  always @(posedge clk) begin
    blur_beat_t got, exp_b;
    if (!rst && pout.valid && pout.ready) begin
      got = '{pout.pixel_out, pout.out_col, pout.out_row, pout.was_filtered,
              pout.last_of_run};
      if (expected_beats.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected beat: %p", got);
      end else begin
        exp_b = expected_beats.pop_front();
        if (got !== exp_b) begin
          err_count++;
          if (err_count <= 10) $display("mismatch: exp %p got %p", exp_b, got);
        end
      end
    end
  end

  initial begin
    pin.valid = 1'b0;
    pin.pixel_in = '0;
    pin.mask_label = '0;
    cfg.valid = 1'b0;
    cfg.index = 1'b0;
    cfg.data = '0;
    width_reg = 640;
    height_reg = 480;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_clamp();
    test_backpressure();
    test_random();
    wait_drained();

    if (err_count == 0 && expected_beats.size() == 0)
      $display("masked_gaussian_blur_3x3 verification clean");
    else
      $display("masked_gaussian_blur_3x3 verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("masked_gaussian_blur_3x3 verification failed");
    $finish;
  end

endmodule
